FILE: design/two_tier_op_rate_limiter_macros.svh
// ------------------------------------------------------------------------
// two_tier_op_rate_limiter_macros.svh
// assertion shorthands used by the checker
// ------------------------------------------------------------------------
`ifndef TWO_TIER_OP_RATE_LIMITER_MACROS_SVH
`define TWO_TIER_OP_RATE_LIMITER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define OTRL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define OTRL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/otrl_pkg.sv
// ------------------------------------------------------------------------
// otrl_pkg
// shared types, codes and widths of the two-tier operation rate limiter
// ------------------------------------------------------------------------
package otrl_pkg;

	// default sizing
	localparam int unsigned DEF_USER_SLOTS   = 256;
	localparam int unsigned DEF_MEMBER_SLOTS = 1024;
	localparam int unsigned DEF_TIME_BITS    = 32;

	// fixed field widths
	localparam int unsigned CMD_W       = 2;
	localparam int unsigned USER_SLOT_W = 8;
	localparam int unsigned MEM_SLOT_W  = 10;
	localparam int unsigned CNT_W       = 16;
	localparam int unsigned NOW_W       = 32;
	localparam int unsigned KINDS       = 3;

	// stream and register port widths
	localparam int unsigned S_TDATA_W = 88;
	localparam int unsigned S_TUSER_W = CMD_W;
	localparam int unsigned M_TDATA_W = 56;
	localparam int unsigned APB_DW    = 32;
	localparam int unsigned PADDR_W   = 5;
	localparam int unsigned REG_IDX_W = 3;

	// operation kinds
	localparam logic [CMD_W-1:0] CMD_KICK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_MODE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PROP = 2'd2;

	// which counter tripped
	localparam logic [1:0] TIER_NONE    = 2'd0;
	localparam logic [1:0] TIER_SERVER  = 2'd1;
	localparam logic [1:0] TIER_CHANNEL = 2'd2;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_KICK_COUNT = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_KICK_TIME  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MODE_COUNT = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_MODE_TIME  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_PROP_COUNT = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_PROP_TIME  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_OPER_EXEMPT = 3'd6;

	// a limit: operations per window and window length
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] window;
	} lim_t;

	// updated counter and trip flag
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             over;
	} tick_res_t;

endpackage

FILE: design/otrl_ram.sv
// ------------------------------------------------------------------------
// otrl_ram
// simple dual-port ram, one write and one registered read port
// ------------------------------------------------------------------------
module otrl_ram #(
	parameter int unsigned WIDTH = 48,
	parameter int unsigned DEPTH = 768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/otrl_slot_map.sv
// ------------------------------------------------------------------------
// otrl_slot_map
// reduces a slot modulo the slot count and forms the table index
// ------------------------------------------------------------------------
module otrl_slot_map
	import otrl_pkg::*;
#(
	parameter int unsigned SLOT_W = 8,
	parameter int unsigned SLOTS  = 256,
	parameter int unsigned ADDR_W = 10
) (
	input  logic              clk,
	input  logic              start,
	input  logic [SLOT_W-1:0] slot,
	input  logic [CMD_W-1:0]  cmd,
	output logic [ADDR_W-1:0] idx
);

	// quotient by reciprocal, exact for every SLOT_W-bit slot
	localparam int unsigned K   = SLOT_W + $clog2(SLOTS);
	localparam int unsigned M_W = K + 1;
	localparam int unsigned D_W = $clog2(SLOTS + 1);
	localparam longint unsigned RECIP = ((64'd1 << K) + SLOTS - 1) / SLOTS;
	localparam logic [M_W-1:0] RECIP_V = M_W'(RECIP);
	localparam logic [D_W-1:0] SLOTS_V = D_W'(SLOTS);

	logic [SLOT_W+M_W-1:0] prod;
	logic [SLOT_W+D_W-1:0] qd;
	logic [SLOT_W-1:0]     rem;
	logic [SLOT_W+1:0]     idx_full;

	logic [SLOT_W-1:0] slot_s1;
	logic [SLOT_W-1:0] q_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic [ADDR_W-1:0] idx_s2;

	assign prod     = (SLOT_W+M_W)'(slot) * (SLOT_W+M_W)'(RECIP_V);
	assign qd       = (SLOT_W+D_W)'(q_s1) * (SLOT_W+D_W)'(SLOTS_V);
	assign rem      = slot_s1 - qd[SLOT_W-1:0];
	// slot * 3 + kind
	assign idx_full = ({2'b00, rem} << 1) + {2'b00, rem} + (SLOT_W+2)'(cmd_s1);

	always_ff @(posedge clk) begin
		if (start) begin
			slot_s1 <= slot;
			q_s1    <= prod[K +: SLOT_W];
			cmd_s1  <= cmd;
		end
		idx_s2 <= ADDR_W'(idx_full);
	end

	assign idx = idx_s2;

endmodule

FILE: design/otrl_tick.sv
// ------------------------------------------------------------------------
// otrl_tick
// fixed-window counter update: restart, saturating increment, limit check
// ------------------------------------------------------------------------
module otrl_tick
	import otrl_pkg::*;
#(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic [TIME_BITS-1:0] now,
	input  logic [TIME_BITS-1:0] start,
	input  logic [CNT_W-1:0]     count,
	input  lim_t                 lim,
	output logic [TIME_BITS-1:0] new_start,
	output tick_res_t            res
);

	logic [TIME_BITS-1:0] diff;
	logic                 restart;
	logic [CNT_W-1:0]     base;

	// wraps modulo the time width
	assign diff    = now - start;
	assign restart = diff >= TIME_BITS'(lim.window);
	assign base    = restart ? '0 : count;

	assign new_start = restart ? now : start;
	assign res.count = (base == '1) ? base : base + CNT_W'(1);
	assign res.over  = res.count > lim.count;

endmodule

FILE: design/two_tier_op_rate_limiter.sv
// ------------------------------------------------------------------------
// two_tier_op_rate_limiter
// per-user and per-membership fixed-window limiter for kick, mode, prop
// ------------------------------------------------------------------------
// usage
//   requests arrive on the s_ stream (cmd in s_tuser, the rest in s_tdata),
//   one verdict per request leaves on the m_ stream. server limits and the
//   operator exemption sit behind the apb port; the user must write them
//   only while idle, and the block itself does not enforce it.
// steps, accept to m_tvalid
//   ST_IDX; if checked, ST_RD and ST_USER for the server counter, then
//   ST_MEM for the channel counter; ST_DONE loads the output register
// sequencing
//   one request at a time; the read-modify-write of the counter rams runs
//   in turn (user entry, then membership entry) through a single tick unit
//   arst_n clears control and loads the register defaults, then a clearing
//   pass zeroes both counter rams, 3 * max(USER_SLOTS, MEMBER_SLOTS) entries
//   (3072 at default size), with s_tready low; apb stays available
// stall
//   the verdict waits in the output register; the next request is taken
//   meanwhile and holds in its last step until the output frees up
// ------------------------------------------------------------------------
module two_tier_op_rate_limiter
	import otrl_pkg::*;
#(
	parameter int unsigned USER_SLOTS   = DEF_USER_SLOTS,
	parameter int unsigned MEMBER_SLOTS = DEF_MEMBER_SLOTS,
	parameter int unsigned TIME_BITS    = DEF_TIME_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// user_slot[7:0] is_local[8] is_god[9] is_operator[10] has_channel[11]
	// member_found[12] member_slot[22:13] chan_limit_valid[23]
	// chan_limit_count[39:24] chan_limit_time[55:40] now_seconds[87:56]
	input  logic [S_TDATA_W-1:0] s_tdata,
	// cmd[1:0]
	input  logic [S_TUSER_W-1:0] s_tuser,
	// verdict stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// throttled[0] tier[2:1] ops_in_window[18:3] applied_count[34:19]
	// applied_time[50:35] zero[55:51]
	output logic [M_TDATA_W-1:0] m_tdata,
	// register port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [APB_DW-1:0]    pwdata,
	output logic [APB_DW-1:0]    prdata,
	output logic                 pready
);

	// table geometry: one entry per slot and kind
	localparam int unsigned U_DEPTH   = USER_SLOTS * KINDS;
	localparam int unsigned M_DEPTH   = MEMBER_SLOTS * KINDS;
	localparam int unsigned UA_W      = $clog2(U_DEPTH);
	localparam int unsigned MA_W      = $clog2(M_DEPTH);
	localparam int unsigned CLR_DEPTH = (U_DEPTH > M_DEPTH) ? U_DEPTH : M_DEPTH;
	localparam int unsigned CLR_W     = $clog2(CLR_DEPTH);
	localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_DEPTH - 1);
	localparam int unsigned ENT_W     = TIME_BITS + CNT_W;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_IDX,
		ST_RD,
		ST_USER,
		ST_MEM,
		ST_DONE
	} state_t;

	state_t           state_q;
	logic [CLR_W-1:0] clr_q;
	logic             m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	// register file
	logic [CNT_W-1:0] lim_cnt_q  [KINDS];
	logic [CNT_W-1:0] lim_time_q [KINDS];
	logic             exempt_q;

	// request fields held for the duration of the request
	logic [CMD_W-1:0]     cmd_q;
	logic                 is_local_q;
	logic                 is_god_q;
	logic                 is_oper_q;
	logic                 has_chan_q;
	logic                 member_found_q;
	logic                 cvalid_q;
	lim_t                 chan_lim_q;
	logic [TIME_BITS-1:0] now_q;

	// cross products for the stricter-limit test
	logic [2*CNT_W-1:0] prod_chan_s2;
	logic [2*CNT_W-1:0] prod_srv_s2;
	logic               stricter_q;

	// verdict being built
	logic             res_thr_q;
	logic [1:0]       res_tier_q;
	logic [CNT_W-1:0] res_ops_q;
	lim_t             res_lim_q;

	logic accept;
	logic out_free;
	logic pass;
	logic go_member;
	logic clr_user;
	logic clr_member;
	lim_t srv_lim;

	logic [UA_W-1:0]  u_idx;
	logic [MA_W-1:0]  m_idx;
	logic             u_we;
	logic [UA_W-1:0]  u_waddr;
	logic [ENT_W-1:0] u_wdata;
	logic [ENT_W-1:0] u_rdata;
	logic             m_we;
	logic [MA_W-1:0]  m_waddr;
	logic [ENT_W-1:0] m_wdata;
	logic [ENT_W-1:0] m_rdata;

	logic [ENT_W-1:0]     tk_entry;
	lim_t                 tk_lim;
	logic [TIME_BITS-1:0] tk_start;
	tick_res_t            tk_res;
	logic [ENT_W-1:0]     tk_wdata;

	logic                 cfg_wr;
	logic [REG_IDX_W-1:0] cfg_idx;

	// ---------------------------------------------------------------------
	// register port
	// ---------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < KINDS; k++) begin
				lim_cnt_q[k]  <= '0;
				lim_time_q[k] <= CNT_W'(1);
			end
			exempt_q <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_KICK_COUNT:  lim_cnt_q[0]  <= pwdata[CNT_W-1:0];
				REG_KICK_TIME:   lim_time_q[0] <= pwdata[CNT_W-1:0];
				REG_MODE_COUNT:  lim_cnt_q[1]  <= pwdata[CNT_W-1:0];
				REG_MODE_TIME:   lim_time_q[1] <= pwdata[CNT_W-1:0];
				REG_PROP_COUNT:  lim_cnt_q[2]  <= pwdata[CNT_W-1:0];
				REG_PROP_TIME:   lim_time_q[2] <= pwdata[CNT_W-1:0];
				REG_OPER_EXEMPT: exempt_q      <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (cfg_idx)
			REG_KICK_COUNT:  prdata = APB_DW'(lim_cnt_q[0]);
			REG_KICK_TIME:   prdata = APB_DW'(lim_time_q[0]);
			REG_MODE_COUNT:  prdata = APB_DW'(lim_cnt_q[1]);
			REG_MODE_TIME:   prdata = APB_DW'(lim_time_q[1]);
			REG_PROP_COUNT:  prdata = APB_DW'(lim_cnt_q[2]);
			REG_PROP_TIME:   prdata = APB_DW'(lim_time_q[2]);
			REG_OPER_EXEMPT: prdata = APB_DW'(exempt_q);
			default:         prdata = '0;
		endcase
	end

	// server limit of the requested kind, zero for the unused code
	always_comb begin
		case (cmd_q)
			CMD_KICK: srv_lim = '{count: lim_cnt_q[0], window: lim_time_q[0]};
			CMD_MODE: srv_lim = '{count: lim_cnt_q[1], window: lim_time_q[1]};
			CMD_PROP: srv_lim = '{count: lim_cnt_q[2], window: lim_time_q[2]};
			default:  srv_lim = '0;
		endcase
	end

	// ---------------------------------------------------------------------
	// handshake and decisions
	// ---------------------------------------------------------------------
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// remote, exempt, disabled or undefined kind: no counter touched
	assign pass = (cmd_q != CMD_KICK && cmd_q != CMD_MODE && cmd_q != CMD_PROP) ||
		!is_local_q || (srv_lim.count == '0) || is_god_q || (is_oper_q && exempt_q);

	// membership counter only after the server counter let it through
	assign go_member = !tk_res.over && stricter_q && member_found_q;

	// ---------------------------------------------------------------------
	// index formation, slots reduced modulo the slot count
	// ---------------------------------------------------------------------
	otrl_slot_map #(
		.SLOT_W (USER_SLOT_W),
		.SLOTS  (USER_SLOTS),
		.ADDR_W (UA_W)
	) u_user_map (
		.clk   (clk),
		.start (accept),
		.slot  (s_tdata[7:0]),
		.cmd   (s_tuser[CMD_W-1:0]),
		.idx   (u_idx)
	);

	otrl_slot_map #(
		.SLOT_W (MEM_SLOT_W),
		.SLOTS  (MEMBER_SLOTS),
		.ADDR_W (MA_W)
	) u_member_map (
		.clk   (clk),
		.start (accept),
		.slot  (s_tdata[22:13]),
		.cmd   (s_tuser[CMD_W-1:0]),
		.idx   (m_idx)
	);

	// ---------------------------------------------------------------------
	// counter tables: {window start, count} per entry
	// ---------------------------------------------------------------------
	assign clr_user   = ({1'b0, clr_q} < (CLR_W+1)'(U_DEPTH));
	assign clr_member = ({1'b0, clr_q} < (CLR_W+1)'(M_DEPTH));

	always_comb begin
		u_we    = 1'b0;
		u_waddr = u_idx;
		u_wdata = tk_wdata;
		m_we    = 1'b0;
		m_waddr = m_idx;
		m_wdata = tk_wdata;
		case (state_q)
			ST_CLR: begin
				u_we    = clr_user;
				u_waddr = UA_W'(clr_q);
				u_wdata = '0;
				m_we    = clr_member;
				m_waddr = MA_W'(clr_q);
				m_wdata = '0;
			end
			ST_USER: u_we = 1'b1;
			ST_MEM:  m_we = 1'b1;
			default: ;
		endcase
	end

	otrl_ram #(
		.WIDTH (ENT_W),
		.DEPTH (U_DEPTH)
	) u_user_ram (
		.clk   (clk),
		.we    (u_we),
		.waddr (u_waddr),
		.wdata (u_wdata),
		.re    (state_q == ST_RD),
		.raddr (u_idx),
		.rdata (u_rdata)
	);

	otrl_ram #(
		.WIDTH (ENT_W),
		.DEPTH (M_DEPTH)
	) u_member_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.re    (state_q == ST_RD),
		.raddr (m_idx),
		.rdata (m_rdata)
	);

	// ---------------------------------------------------------------------
	// one tick unit, user entry first, membership entry after
	// ---------------------------------------------------------------------
	assign tk_entry = (state_q == ST_MEM) ? m_rdata : u_rdata;
	assign tk_lim   = (state_q == ST_MEM) ? chan_lim_q : srv_lim;

	otrl_tick #(
		.TIME_BITS (TIME_BITS)
	) u_tick (
		.now       (now_q),
		.start     (tk_entry[ENT_W-1:CNT_W]),
		.count     (tk_entry[CNT_W-1:0]),
		.lim       (tk_lim),
		.new_start (tk_start),
		.res       (tk_res)
	);

	assign tk_wdata = {tk_start, tk_res.count};

	// ---------------------------------------------------------------------
	// sequencer
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			case (state_q)
				ST_CLR: begin
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + CLR_W'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_IDX;
					end
				end
				ST_IDX:  state_q <= pass ? ST_DONE : ST_RD;
				ST_RD:   state_q <= ST_USER;
				ST_USER: state_q <= go_member ? ST_MEM : ST_DONE;
				ST_MEM:  state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// verdict leaves through the output register
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= {5'b0, res_lim_q.window, res_lim_q.count, res_ops_q,
					res_tier_q, res_thr_q};
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// request fields, products and verdict
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q            <= s_tuser[CMD_W-1:0];
			is_local_q       <= s_tdata[8];
			is_god_q         <= s_tdata[9];
			is_oper_q        <= s_tdata[10];
			has_chan_q       <= s_tdata[11];
			member_found_q   <= s_tdata[12];
			cvalid_q         <= s_tdata[23];
			chan_lim_q.count  <= s_tdata[39:24];
			chan_lim_q.window <= s_tdata[55:40];
			now_q            <= TIME_BITS'(s_tdata[87:56]);
		end
		case (state_q)
			ST_IDX: begin
				prod_chan_s2 <= chan_lim_q.count * srv_lim.window;
				prod_srv_s2  <= srv_lim.count * chan_lim_q.window;
				// an unchecked pass reports all zero
				res_thr_q  <= 1'b0;
				res_tier_q <= TIER_NONE;
				res_ops_q  <= '0;
				res_lim_q  <= '0;
			end
			ST_RD: begin
				stricter_q <= has_chan_q && cvalid_q && (chan_lim_q.count != '0) &&
					(chan_lim_q.window != '0) && (prod_chan_s2 < prod_srv_s2);
			end
			ST_USER: begin
				res_thr_q  <= tk_res.over;
				res_tier_q <= tk_res.over ? TIER_SERVER : TIER_NONE;
				res_ops_q  <= tk_res.count;
				res_lim_q  <= srv_lim;
			end
			ST_MEM: begin
				res_thr_q  <= tk_res.over;
				res_tier_q <= tk_res.over ? TIER_CHANNEL : TIER_NONE;
				res_ops_q  <= tk_res.count;
				res_lim_q  <= chan_lim_q;
			end
			default: ;
		endcase
	end

endmodule

FILE: design/otrl_checker.sv
// ------------------------------------------------------------------------
// otrl_checker
// port-level checks of the two-tier operation rate limiter
// ------------------------------------------------------------------------
`include "two_tier_op_rate_limiter_macros.svh"

module otrl_checker
	import otrl_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// throttled exactly when some tier tripped, never the unused tier code
	`OTRL_ASSERT_IMP(a_tier_match, clk, arst_n, m_tvalid, (m_tdata[0] == (m_tdata[2:1] != TIER_NONE)) && (m_tdata[2:1] <= TIER_CHANNEL), "tier and throttled disagree")

	// a refusal means the checked count went past its limit
	`OTRL_ASSERT_IMP(a_thr_over, clk, arst_n, m_tvalid && m_tdata[0], m_tdata[18:3] > m_tdata[34:19], "throttled without exceeding limit")

	// a granted request stays within the limit it was checked against
	`OTRL_ASSERT_IMP(a_pass_within, clk, arst_n, m_tvalid && !m_tdata[0], m_tdata[18:3] <= m_tdata[34:19], "count over limit but not throttled")

	// one request in flight: no second transfer right after an accepted one
	`OTRL_ASSERT_NXT(a_one_inflight, clk, arst_n, s_tvalid && s_tready, !s_tready, "input ready right after a transfer")

	// a stalled verdict holds
	`OTRL_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "verdict changed under stall")

endmodule

bind two_tier_op_rate_limiter otrl_checker u_otrl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
